@@ rtl/pthm_pkg.sv @@
// Package with the shared types and status codes of the hit merger.
`timescale 1ns / 1ps
package pthm_pkg;

    typedef enum logic [2:0] {
        ST_REJECTED = 3'd0,
        ST_MERGED   = 3'd1,
        ST_NEW      = 3'd2,
        ST_FULL     = 3'd3,
        ST_HIT      = 3'd4,
        ST_EMPTY    = 3'd5
    } status_t;

    typedef struct packed {
        logic [15:0]        pad;
        logic [23:0]        track;
        logic [31:0]        energy;
        logic [31:0]        hit_time;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic [31:0]        path;
        logic signed [31:0] particle;
    } entry_t;

    // Result of comparing one stored entry with the deposit.
    typedef struct packed {
        logic        match;
        logic        earlier;
        logic [31:0] energy_sum;
    } cmp_t;

endpackage

@@ rtl/pthm_compare.sv @@
// Shared compare and saturating add unit used once per scanned entry.
`timescale 1ns / 1ps
module pthm_compare (
    input  pthm_pkg::entry_t entry,
    input  logic [15:0]      pad_id,
    input  logic [23:0]      track_id,
    input  logic [31:0]      energy,
    input  logic [31:0]      hit_time,
    input  logic [15:0]      time_window,
    output pthm_pkg::cmp_t   result
);
    logic [31:0] diff;
    logic [32:0] sum;

    always_comb begin
        diff = (hit_time >= entry.hit_time) ? (hit_time - entry.hit_time)
                                            : (entry.hit_time - hit_time);
        sum  = {1'b0, entry.energy} + {1'b0, energy};
        result.match      = (entry.pad == pad_id) && (entry.track == track_id) &&
                            (diff <= {16'd0, time_window});
        result.earlier    = hit_time < entry.hit_time;
        result.energy_sum = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end
endmodule

@@ rtl/pad_track_hit_merger.sv @@
// Top level of the pad and track hit merger with its table and sequencer.
`timescale 1ns / 1ps
// Accumulates energy deposits into a table of up to TABLE_DEPTH hits keyed
// by pad and track. A record request scans the stored hits in insertion
// order through one shared compare and add unit. Each stored entry checked
// takes a read step and then a compare step. A merge with an entry ends the
// scan and presents the merged hit. Without a match, all stored entries are
// scanned and the new entry or the drop is reported. An uncharged deposit is
// reported on the cycle after acceptance. A readout request takes each stored
// hit through a read, a load and a present step and then waits for the output
// side to take it. The last hit carries last, and the table is then emptied.
// An empty table gives one result with status empty on the cycle after
// acceptance. Every result waits in the output register until taken. The
// block accepts no request while one is busy and is ready again on the
// cycle after its final result is taken. The time window register may be
// written whenever the block is idle.
module pad_track_hit_merger #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_operation,
    input  logic               s_charged,
    input  logic [15:0]        s_pad_id,
    input  logic [23:0]        s_track_id,
    input  logic [31:0]        s_energy,
    input  logic [31:0]        s_hit_time,
    input  logic signed [23:0] s_pos_x,
    input  logic signed [23:0] s_pos_y,
    input  logic signed [23:0] s_pos_z,
    input  logic [31:0]        s_path_length,
    input  logic signed [31:0] s_particle_code,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic [4:0]         m_slot,
    output logic [15:0]        m_hit_pad,
    output logic [23:0]        m_hit_track,
    output logic [31:0]        m_energy_sum,
    output logic [31:0]        m_earliest_time,
    output logic signed [23:0] m_hit_x,
    output logic signed [23:0] m_hit_y,
    output logic signed [23:0] m_hit_z,
    output logic [31:0]        m_hit_path,
    output logic signed [31:0] m_hit_particle,
    output logic               m_last
);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_READ  = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_WRITE = 7'b0001000,
        S_OUT   = 7'b0010000,
        S_DUMP  = 7'b0100000,
        S_LOAD  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [15:0] window_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    pthm_pkg::entry_t mem [TABLE_DEPTH];
    pthm_pkg::entry_t rd_reg;
    pthm_pkg::entry_t dep_reg;
    pthm_pkg::entry_t wr_data;
    logic wr_en;
    logic rd_en;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic [2:0] status_reg;
    logic [4:0] slot_reg;
    pthm_pkg::entry_t out_reg;
    logic last_reg;
    logic mvalid_reg;
    pthm_pkg::cmp_t cmp;

    pthm_compare u_cmp (
        .entry      (rd_reg),
        .pad_id     (dep_reg.pad),
        .track_id   (dep_reg.track),
        .energy     (dep_reg.energy),
        .hit_time   (dep_reg.hit_time),
        .time_window(window_reg),
        .result     (cmp)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign rd_addr = idx_reg[IW-1:0];
    assign wr_addr = idx_reg[IW-1:0];

    // The scanning index drives the read port; data lands in rd_reg.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_comb begin
        rd_en = (state_reg == S_READ) || (state_reg == S_DUMP);
        wr_en = 1'b0;
        wr_data = dep_reg;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_operation) begin
                        // An empty table answers at once with status empty.
                        state_next = (count_reg == '0) ? S_OUT : S_DUMP;
                    end else if (!s_charged) begin
                        state_next = S_OUT;
                    end else begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ: begin
                // Scan end is reached when every stored entry was checked.
                if (idx_reg >= count_reg) begin
                    state_next = S_WRITE;
                end else begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (cmp.match) begin
                    wr_en = 1'b1;
                    wr_data = rd_reg;
                    wr_data.energy = cmp.energy_sum;
                    if (cmp.earlier) begin
                        wr_data.hit_time = dep_reg.hit_time;
                        wr_data.x = dep_reg.x;
                        wr_data.y = dep_reg.y;
                        wr_data.z = dep_reg.z;
                        wr_data.path = dep_reg.path;
                    end
                    state_next = S_OUT;
                end else begin
                    state_next = S_READ;
                end
            end
            S_WRITE: begin
                wr_en = (count_reg < CW'(TABLE_DEPTH));
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_ready) begin
                    state_next = last_reg ? S_IDLE : S_DUMP;
                end
            end
            S_DUMP: begin
                state_next = S_LOAD;
            end
            S_LOAD: begin
                state_next = S_OUT;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            window_reg <= 16'd5000;
            count_reg  <= '0;
            idx_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                window_reg <= cfg_wdata;
            end
            case (state_reg)
                S_IDLE: begin
                    idx_reg <= '0;
                    if (s_valid && !s_operation && !s_charged) begin
                        mvalid_reg <= 1'b1;
                        status_reg <= pthm_pkg::ST_REJECTED;
                        slot_reg   <= '0;
                        out_reg    <= '0;
                        last_reg   <= 1'b1;
                    end
                    if (s_valid && s_operation && (count_reg == '0)) begin
                        mvalid_reg <= 1'b1;
                        status_reg <= pthm_pkg::ST_EMPTY;
                        slot_reg   <= '0;
                        out_reg    <= '0;
                        last_reg   <= 1'b1;
                    end
                    if (s_valid) begin
                        dep_reg.pad      <= s_pad_id;
                        dep_reg.track    <= s_track_id;
                        dep_reg.energy   <= s_energy;
                        dep_reg.hit_time <= s_hit_time;
                        dep_reg.x        <= s_pos_x;
                        dep_reg.y        <= s_pos_y;
                        dep_reg.z        <= s_pos_z;
                        dep_reg.path     <= s_path_length;
                        dep_reg.particle <= s_particle_code;
                    end
                end
                S_CHECK: begin
                    if (cmp.match) begin
                        mvalid_reg <= 1'b1;
                        status_reg <= pthm_pkg::ST_MERGED;
                        slot_reg   <= 5'(idx_reg);
                        out_reg    <= wr_data;
                        last_reg   <= 1'b1;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_WRITE: begin
                    mvalid_reg <= 1'b1;
                    last_reg   <= 1'b1;
                    if (wr_en) begin
                        status_reg <= pthm_pkg::ST_NEW;
                        slot_reg   <= 5'(idx_reg);
                        out_reg    <= dep_reg;
                        count_reg  <= count_reg + 1'b1;
                    end else begin
                        status_reg <= pthm_pkg::ST_FULL;
                        slot_reg   <= '0;
                        out_reg    <= '0;
                    end
                end
                S_LOAD: begin
                    // The hit read in the dump step is now in rd_reg.
                    mvalid_reg <= 1'b1;
                    status_reg <= pthm_pkg::ST_HIT;
                    slot_reg   <= 5'(idx_reg);
                    out_reg    <= rd_reg;
                    last_reg   <= ((idx_reg + 1'b1) == count_reg);
                end
                S_OUT: begin
                    if (m_ready) begin
                        mvalid_reg <= 1'b0;
                        if (!last_reg) begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                        // The final hit of a readout empties the table.
                        if (last_reg && (status_reg == pthm_pkg::ST_HIT)) begin
                            count_reg <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid         = mvalid_reg;
    assign m_status        = status_reg;
    assign m_slot          = slot_reg;
    assign m_hit_pad       = out_reg.pad;
    assign m_hit_track     = out_reg.track;
    assign m_energy_sum    = out_reg.energy;
    assign m_earliest_time = out_reg.hit_time;
    assign m_hit_x         = out_reg.x;
    assign m_hit_y         = out_reg.y;
    assign m_hit_z         = out_reg.z;
    assign m_hit_path      = out_reg.path;
    assign m_hit_particle  = out_reg.particle;
    assign m_last          = last_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !mvalid_reg)
        else $error("request accepted while a result is pending");
    a_dump_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && m_valid && m_ready && m_last &&
         m_status == pthm_pkg::ST_HIT) |=> count_reg == '0)
        else $error("table not cleared after readout");
endmodule
